/* hw/rtl/noise_gate_envelope_hysteresis_core_assert.svh */
// assertion macros for the noise gate core
// expects clk and rst_n in the scope where a macro is used
`ifndef NOISE_GATE_ENVELOPE_HYSTERESIS_CORE_ASSERT_SVH
`define NOISE_GATE_ENVELOPE_HYSTERESIS_CORE_ASSERT_SVH

// same-cycle implication
`define NGEH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NGEH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ngeh_pkg.sv */
// types, register codes and reset values for the noise gate core
// no dependencies
package ngeh_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int COEFF_BITS    = 16;
  localparam int GAIN_BITS     = COEFF_BITS + 1;
  localparam int NGEH_CHANNELS = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ATTACK_COEFF    = 3'd0,
    REG_RELEASE_COEFF   = 3'd1,
    REG_OPEN_THRESHOLD  = 3'd2,
    REG_CLOSE_THRESHOLD = 3'd3,
    REG_CLOSED_GAIN     = 3'd4
  } ngeh_reg_t;

  localparam logic [COEFF_BITS-1:0]  ATTACK_RST  = COEFF_BITS'(6554);
  localparam logic [COEFF_BITS-1:0]  RELEASE_RST = COEFF_BITS'(66);
  localparam logic [SAMPLE_BITS-1:0] OPEN_RST    = SAMPLE_BITS'(83886);
  localparam logic [SAMPLE_BITS-1:0] CLOSE_RST   = SAMPLE_BITS'(41943);
  localparam logic [GAIN_BITS-1:0]   GAIN_RST    = GAIN_BITS'(6554);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          channel;
  } ngeh_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          gate_is_open;
  } ngeh_out_t;

endpackage

/* hw/rtl/noise_gate_envelope_hysteresis_core.sv */
// noise gate with per-channel envelope follower and open/close hysteresis
// depends on ngeh_pkg and noise_gate_envelope_hysteresis_core_assert.svh
//
// usage:
//   in_valid/in_stall carry one beat per sample (signed sample and channel)
//   out_valid/out_stall carry one beat per result (gated sample, gate state)
//   cfg_valid/cfg_ready write one register per beat; cfg_ready is always high,
//   index 0 attack, 1 release, 2 open threshold, 3 close threshold,
//   4 closed gain; other indexes are ignored
// timing:
//   one beat per cycle sustained while out_stall is low; a result passes
//   through the input register, then envelope update and gain into the
//   output register. a channel's envelope is written back as its sample
//   moves on, so samples of the same channel may follow each other directly
// reset:
//   envelopes go to zero, all gates closed, registers to their defaults
// stall:
//   while out_stall holds a waiting result, one more sample is taken into
//   the input register; after that in_stall rises until the result leaves
module noise_gate_envelope_hysteresis_core #(
  parameter int CHANNELS = ngeh_pkg::NGEH_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ngeh_pkg::ngeh_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ngeh_pkg::ngeh_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ngeh_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ngeh_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import ngeh_pkg::*;

  localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PROD_BITS   = GAIN_BITS + SAMPLE_BITS + 1;
  localparam int WIDE_BITS   = SAMPLE_BITS + 2;
  localparam logic signed [WIDE_BITS-1:0] SAT_MAX =
    WIDE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [WIDE_BITS-1:0] SAT_MIN =
    WIDE_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  `include "noise_gate_envelope_hysteresis_core_assert.svh"

  logic [COEFF_BITS-1:0]  attack_r;
  logic [COEFF_BITS-1:0]  release_r;
  logic [SAMPLE_BITS-1:0] open_thr_r;
  logic [SAMPLE_BITS-1:0] close_thr_r;
  logic [GAIN_BITS-1:0]   gain_r;

  logic [SAMPLE_BITS-1:0] env_r  [CHANNELS];
  logic                   gate_r [CHANNELS];

  logic      stg_valid_r, stg_valid_nxt;
  ngeh_in_t  stg_data_r;
  logic      out_valid_r, out_valid_nxt;
  ngeh_out_t out_data_r, out_data_nxt;

  logic                          load;
  logic                          adv;
  logic                          in_range;
  logic [CH_IDX_BITS-1:0]        ch_idx;
  logic signed [SAMPLE_BITS-1:0] x;
  logic [SAMPLE_BITS-1:0]        env_cur;
  logic                          gate_cur;
  logic signed [SAMPLE_BITS:0]   x_ext;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [COEFF_BITS-1:0]         coeff;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PROD_BITS-1:0]   env_prod;
  logic signed [WIDE_BITS-1:0]   env_sum;
  logic [SAMPLE_BITS-1:0]        env_nxt;
  logic                          gate_nxt;
  logic signed [PROD_BITS-1:0]   gain_prod;
  logic signed [WIDE_BITS-1:0]   gained;
  logic signed [SAMPLE_BITS-1:0] gained_sat;

  assign cfg_ready = 1'b1;
  assign in_stall  = stg_valid_r && out_valid_r && out_stall;
  assign load      = in_valid && !in_stall;
  assign adv       = stg_valid_r && !(out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r    <= ATTACK_RST;
      release_r   <= RELEASE_RST;
      open_thr_r  <= OPEN_RST;
      close_thr_r <= CLOSE_RST;
      gain_r      <= GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (ngeh_reg_t'(cfg_index))
        REG_ATTACK_COEFF:    attack_r    <= cfg_data[COEFF_BITS-1:0];
        REG_RELEASE_COEFF:   release_r   <= cfg_data[COEFF_BITS-1:0];
        REG_OPEN_THRESHOLD:  open_thr_r  <= cfg_data[SAMPLE_BITS-1:0];
        REG_CLOSE_THRESHOLD: close_thr_r <= cfg_data[SAMPLE_BITS-1:0];
        REG_CLOSED_GAIN:     gain_r      <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // envelope update, hysteresis and gain
  always_comb begin
    x        = stg_data_r.sample_in;
    in_range = 32'(stg_data_r.channel) < 32'(CHANNELS);
    ch_idx   = CH_IDX_BITS'(stg_data_r.channel);
    env_cur  = env_r[ch_idx];
    gate_cur = gate_r[ch_idx];

    x_ext    = {x[SAMPLE_BITS-1], x};
    mag      = x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_ext) : SAMPLE_BITS'(x_ext);
    coeff    = (mag > env_cur) ? attack_r : release_r;
    diff     = $signed({1'b0, mag}) - $signed({1'b0, env_cur});
    env_prod = $signed({1'b0, coeff}) * diff;
    env_sum  = $signed({2'b00, env_cur}) + env_prod[PROD_BITS-1:COEFF_BITS];
    env_nxt  = env_sum[SAMPLE_BITS-1:0];

    if (gate_cur) begin
      gate_nxt = !(env_nxt < close_thr_r);
    end else begin
      gate_nxt = env_nxt > open_thr_r;
    end

    gain_prod = $signed({1'b0, gain_r}) * x;
    gained    = gain_prod[PROD_BITS-1:COEFF_BITS];
    if (gained > SAT_MAX) begin
      gained_sat = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (gained < SAT_MIN) begin
      gained_sat = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      gained_sat = gained[SAMPLE_BITS-1:0];
    end

    if (!in_range) begin
      out_data_nxt.sample_out   = x;
      out_data_nxt.gate_is_open = 1'b0;
    end else begin
      out_data_nxt.sample_out   = gate_nxt ? x : gained_sat;
      out_data_nxt.gate_is_open = gate_nxt;
    end

    if (load) begin
      stg_valid_nxt = 1'b1;
    end else if (adv) begin
      stg_valid_nxt = 1'b0;
    end else begin
      stg_valid_nxt = stg_valid_r;
    end
    out_valid_nxt = adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        env_r[i]  <= '0;
        gate_r[i] <= 1'b0;
      end
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv && in_range) begin
        env_r[ch_idx]  <= env_nxt;
        gate_r[ch_idx] <= gate_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stg_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  `NGEH_ASSERT_NOW(a_stall_only_full, in_stall, stg_valid_r, "input stalled with empty stage")
  `NGEH_ASSERT_NEXT(a_adv_gives_beat, adv, out_valid_r, "advanced item produced no beat")
  `NGEH_ASSERT_NEXT(a_bad_ch_closed, adv && !in_range,
                    !out_data_r.gate_is_open, "bad channel open")
  `NGEH_ASSERT_NEXT(a_gate_matches, adv && in_range,
                    gate_r[$past(ch_idx)] == out_data_r.gate_is_open, "gate state mismatch")

endmodule

/* bench/noise_gate_envelope_hysteresis_core_tb.sv */
`timescale 1ns / 1ps
// testbench for noise_gate_envelope_hysteresis_core: directed and random samples checked
// against an in-bench envelope and gate predictor, with random input gaps and result stalls
// depends on ngeh_pkg and the core RTL

module noise_gate_envelope_hysteresis_core_tb;
  import ngeh_pkg::*;

  localparam longint      SAT_MAX  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint      SAT_MIN  = -SAT_MAX - 1;
  localparam int unsigned FULL_MAG = 1 << (SAMPLE_BITS - 1);
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = SAMPLE_BITS'(SAT_MAX);
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = SAMPLE_BITS'(SAT_MIN);

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  ngeh_in_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  ngeh_out_t                out_data;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // predictor registers and per-channel state
  logic [COEFF_BITS-1:0]  attack_k;
  logic [COEFF_BITS-1:0]  release_k;
  logic [SAMPLE_BITS-1:0] open_thr;
  logic [SAMPLE_BITS-1:0] close_thr;
  logic [GAIN_BITS-1:0]   closed_gain;
  logic [SAMPLE_BITS-1:0] env_level [NGEH_CHANNELS];
  logic                   gate_open [NGEH_CHANNELS];

  ngeh_out_t pending_gated [$];
  int        errors = 0;
  bit        gaps_on = 1'b0;
  int        rx_hold_len = 0;

  noise_gate_envelope_hysteresis_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_predictor();
    attack_k    = ATTACK_RST;
    release_k   = RELEASE_RST;
    open_thr    = OPEN_RST;
    close_thr   = CLOSE_RST;
    closed_gain = GAIN_RST;
    for (int i = 0; i < NGEH_CHANNELS; i++) begin
      env_level[i] = '0;
      gate_open[i] = 1'b0;
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      REG_ATTACK_COEFF:    attack_k    = val[COEFF_BITS-1:0];
      REG_RELEASE_COEFF:   release_k   = val[COEFF_BITS-1:0];
      REG_OPEN_THRESHOLD:  open_thr    = val[SAMPLE_BITS-1:0];
      REG_CLOSE_THRESHOLD: close_thr   = val[SAMPLE_BITS-1:0];
      REG_CLOSED_GAIN:     closed_gain = val[GAIN_BITS-1:0];
      default: ;
    endcase
  endfunction

  // envelope update, hysteresis decision and closed-gate gain for one beat
  function automatic ngeh_out_t predict_gated_sample(input ngeh_in_t beat);
    longint                x;
    longint                mag;
    longint                env_old;
    longint                y;
    logic [COEFF_BITS-1:0] k;
    int                    ch;
    ngeh_out_t             res;
    x       = longint'($signed(beat.sample_in));
    ch      = int'(beat.channel);
    mag     = (x < 0) ? -x : x;
    env_old = longint'(env_level[ch]);
    k       = (mag > env_old) ? attack_k : release_k;
    env_level[ch] = SAMPLE_BITS'(env_old + ((longint'(k) * (mag - env_old)) >>> COEFF_BITS));
    if (gate_open[ch]) begin
      if (env_level[ch] < close_thr) gate_open[ch] = 1'b0;
    end else if (env_level[ch] > open_thr) begin
      gate_open[ch] = 1'b1;
    end
    if (gate_open[ch]) begin
      y = x;
    end else begin
      y = (x * longint'(closed_gain)) >>> COEFF_BITS;
      if (y > SAT_MAX) y = SAT_MAX;
      if (y < SAT_MIN) y = SAT_MIN;
    end
    res.sample_out   = y[SAMPLE_BITS-1:0];
    res.gate_is_open = gate_open[ch];
    return res;
  endfunction

  always @(posedge clk) begin : scoreboard
    ngeh_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_gated.size() == 0) begin
          $error("unexpected result beat: sample_out %0d", $signed(out_data.sample_out));
          errors++;
        end else begin
          want = pending_gated.pop_front();
          if (out_data.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(want.sample_out), $signed(out_data.sample_out));
            errors++;
          end
          if (out_data.gate_is_open !== want.gate_is_open) begin
            $error("gate_is_open: expected %0b, got %0b",
                   want.gate_is_open, out_data.gate_is_open);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) pending_gated.push_back(predict_gated_sample(in_data));
    end
  end

  // result side stalls: long hold on request, otherwise random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_len != 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold_len) @(negedge clk);
        rx_hold_len = 0;
        out_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic ch);
    ngeh_in_t beat;
    beat.sample_in = s;
    beat.channel   = ch;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_gated.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits carry junk
  function automatic logic [CFG_DATA_BITS-1:0] with_junk(input int unsigned val,
                                                          input int width);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = $urandom;
    return (junk << width) | CFG_DATA_BITS'(val);
  endfunction

  task automatic set_config(input int unsigned atk, input int unsigned rel,
                            input int unsigned opn, input int unsigned cls,
                            input int unsigned gain);
    write_reg(REG_ATTACK_COEFF, with_junk(atk, COEFF_BITS));
    write_reg(REG_RELEASE_COEFF, with_junk(rel, COEFF_BITS));
    write_reg(REG_OPEN_THRESHOLD, with_junk(opn, SAMPLE_BITS));
    write_reg(REG_CLOSE_THRESHOLD, with_junk(cls, SAMPLE_BITS));
    write_reg(REG_CLOSED_GAIN, with_junk(gain, GAIN_BITS));
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] shape_sample(input int unsigned m,
                                                                 input bit neg);
    if (neg) return SAMPLE_BITS'(-longint'(m));
    return (m > FULL_MAG - 1) ? S_MAX : SAMPLE_BITS'(m);
  endfunction

  function automatic int unsigned rand_coeff();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(1, 65534);
    endcase
  endfunction

  task automatic randomize_registers();
    int unsigned opn;
    int unsigned cls;
    int unsigned gain;
    opn  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, (1 << SAMPLE_BITS) - 1)
                                       : $urandom_range(0, FULL_MAG);
    cls  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, (1 << SAMPLE_BITS) - 1)
                                       : $urandom_range(0, opn);
    gain = ($urandom_range(0, 5) == 0) ? $urandom_range(65537, (1 << GAIN_BITS) - 1)
                                       : $urandom_range(0, 65536);
    set_config(rand_coeff(), rand_coeff(), opn, cls, gain);
  endtask

  // mostly loud bursts near or above the open level followed by quiet tails, some noise
  task automatic run_random_items(input int n);
    int          sent;
    int          len;
    int unsigned lvl;
    int unsigned quiet;
    logic        ch;
    sent = 0;
    while (sent < n) begin
      ch = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 7) begin
        lvl = int'(open_thr) + $urandom_range(0, 1 << 20);
        if (lvl > FULL_MAG) lvl = FULL_MAG;
        len = $urandom_range(3, 16);
        repeat (len) begin
          send_sample(shape_sample(lvl - $urandom_range(0, lvl / 8),
                                   1'($urandom_range(0, 1))),
                      ch ^ ($urandom_range(0, 3) == 0));
          sent++;
        end
        quiet = 32'(close_thr) / 2;
        len = $urandom_range(3, 24);
        repeat (len) begin
          send_sample(shape_sample($urandom_range(0, quiet), 1'($urandom_range(0, 1))),
                      ch ^ ($urandom_range(0, 3) == 0));
          sent++;
        end
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          send_sample(SAMPLE_BITS'($urandom), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
    idle_input();
  endtask

  task automatic test_reset_defaults();
    send_sample('0, 1'b0);
    send_sample(1, 1'b1);
    send_sample(-1, 1'b0);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b0);
    idle_input();
  endtask

  task automatic test_register_extremes();
    wait_drained();
    set_config(65535, 65535, 0, 0, (1 << GAIN_BITS) - 1);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b1);
    send_sample('0, 1'b0);
    idle_input();
    wait_drained();
    set_config(0, 0, (1 << SAMPLE_BITS) - 1, (1 << SAMPLE_BITS) - 1, (1 << GAIN_BITS) - 1);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b1);
    idle_input();
    wait_drained();
    write_reg(REG_CLOSED_GAIN, 0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    idle_input();
    wait_drained();
    write_reg(REG_CLOSED_GAIN, 65536);
    send_sample(-1, 1'b0);
    send_sample(S_MAX, 1'b1);
    idle_input();
    wait_drained();
    // writes to unmapped indexes must leave every register alone
    for (int i = int'(REG_CLOSED_GAIN) + 1; i < (1 << CFG_IDX_BITS); i++)
      write_reg(CFG_IDX_BITS'(i), '1);
    send_sample(S_MIN, 1'b0);
    idle_input();
  endtask

  task automatic test_hysteresis();
    wait_drained();
    set_config(65535, 65535, 1000000, 500000, 6554);
    send_sample(600000, 1'b0);
    send_sample(1200000, 1'b0);
    send_sample(-700000, 1'b0);
    send_sample(400000, 1'b0);
    send_sample(-800000, 1'b0);
    idle_input();
  endtask

  task automatic test_backpressure();
    wait_drained();
    rx_hold_len = 60;
    repeat (20) send_sample(SAMPLE_BITS'($urandom), 1'($urandom_range(0, 1)));
    idle_input();
    wait_drained();
    repeat (10) send_sample(SAMPLE_BITS'($urandom), 1'($urandom_range(0, 1)));
    idle_input();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 4) gaps_on = 1'b0;
      wait_drained();
      randomize_registers();
      run_random_items(95);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    reset_predictor();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n   <= 1'b1;
    gaps_on = 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_hysteresis();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ngeh_pkg.sv
hw/rtl/noise_gate_envelope_hysteresis_core.sv
bench/noise_gate_envelope_hysteresis_core_tb.sv
